// ----- hw/rtl/los_pkg.sv -----
// Package for the lateral offset avoid sequencer.
// Holds the request codes, the register set and beat types shared by all modules.
// No dependencies.
package los_pkg;

   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_VISION  = 3'd1;
   localparam logic [2:0] REQ_FORCE   = 3'd2;
   localparam logic [2:0] REQ_ENABLE  = 3'd3;
   localparam logic [2:0] REQ_DISABLE = 3'd4;

   localparam logic [2:0] CSR_RIGHT_MAX      = 3'd0;
   localparam logic [2:0] CSR_LEFT_MAX       = 3'd1;
   localparam logic [2:0] CSR_RING_RIGHT_MAX = 3'd2;
   localparam logic [2:0] CSR_RING_LEFT_MAX  = 3'd3;
   localparam logic [2:0] CSR_SHIFT_STEP     = 3'd4;
   localparam logic [2:0] CSR_RETURN_STEP    = 3'd5;
   localparam logic [2:0] CSR_HOLD_TICKS     = 3'd6;

   localparam logic [1:0] TARGET_NONE  = 2'd0;
   localparam logic [1:0] TARGET_LEFT  = 2'd1;
   localparam logic [1:0] TARGET_RIGHT = 2'd2;

   localparam logic [7:0] SIDE_MAX_LIMIT = 8'd160;
   localparam logic [6:0] RING_MAX_LIMIT = 7'd100;
   localparam logic [5:0] STEP_LIMIT     = 6'd40;
   localparam logic [8:0] HOLD_LIMIT     = 9'd500;

   typedef struct packed {
      logic [7:0] right_max;
      logic [7:0] left_max;
      logic [6:0] ring_right_max;
      logic [6:0] ring_left_max;
      logic [5:0] shift_step;
      logic [5:0] return_step;
      logic [8:0] hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [1:0] target_code;
      logic       on_ring;
   } item_type;

endpackage

// ----- hw/rtl/los_csr.sv -----
// Configuration registers of the lateral offset sequencer, saturated on write.
// Depends on los_pkg.
module los_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_addr,
   input  logic [8:0]       csr_wdata,
   output los_pkg::cfg_type cfg
);

   los_pkg::cfg_type cfg_ff;
   los_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            los_pkg::CSR_RIGHT_MAX: begin
               cfg_in.right_max = (csr_wdata[7:0] > los_pkg::SIDE_MAX_LIMIT) ?
                                  los_pkg::SIDE_MAX_LIMIT : csr_wdata[7:0];
            end
            los_pkg::CSR_LEFT_MAX: begin
               cfg_in.left_max = (csr_wdata[7:0] > los_pkg::SIDE_MAX_LIMIT) ?
                                 los_pkg::SIDE_MAX_LIMIT : csr_wdata[7:0];
            end
            los_pkg::CSR_RING_RIGHT_MAX: begin
               cfg_in.ring_right_max = (csr_wdata[6:0] > los_pkg::RING_MAX_LIMIT) ?
                                       los_pkg::RING_MAX_LIMIT : csr_wdata[6:0];
            end
            los_pkg::CSR_RING_LEFT_MAX: begin
               cfg_in.ring_left_max = (csr_wdata[6:0] > los_pkg::RING_MAX_LIMIT) ?
                                      los_pkg::RING_MAX_LIMIT : csr_wdata[6:0];
            end
            los_pkg::CSR_SHIFT_STEP: begin
               if (csr_wdata[5:0] == 6'd0) begin
                  cfg_in.shift_step = 6'd1;
               end else if (csr_wdata[5:0] > los_pkg::STEP_LIMIT) begin
                  cfg_in.shift_step = los_pkg::STEP_LIMIT;
               end else begin
                  cfg_in.shift_step = csr_wdata[5:0];
               end
            end
            los_pkg::CSR_RETURN_STEP: begin
               if (csr_wdata[5:0] == 6'd0) begin
                  cfg_in.return_step = 6'd1;
               end else if (csr_wdata[5:0] > los_pkg::STEP_LIMIT) begin
                  cfg_in.return_step = los_pkg::STEP_LIMIT;
               end else begin
                  cfg_in.return_step = csr_wdata[5:0];
               end
            end
            los_pkg::CSR_HOLD_TICKS: begin
               cfg_in.hold_ticks = (csr_wdata > los_pkg::HOLD_LIMIT) ?
                                   los_pkg::HOLD_LIMIT : csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_max      <= 8'd60;
         cfg_ff.left_max       <= 8'd60;
         cfg_ff.ring_right_max <= 7'd24;
         cfg_ff.ring_left_max  <= 7'd24;
         cfg_ff.shift_step     <= 6'd6;
         cfg_ff.return_step    <= 6'd4;
         cfg_ff.hold_ticks     <= 9'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/los_core.sv -----
// Mode machine and bias ramp of the lateral offset sequencer; the state
// registers double as the result register. Depends on los_pkg.
module los_core (
   input  logic              clock,
   input  logic              reset,
   input  los_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  los_pkg::item_type item,
   output logic              item_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [8:0] out_bias,
   output logic [2:0]        out_mode
);

   typedef enum logic [2:0] {
      MODE_DISABLED = 3'd0,
      MODE_IDLE     = 3'd1,
      MODE_SHIFT    = 3'd2,
      MODE_HOLD     = 3'd3,
      MODE_RETURN   = 3'd4,
      MODE_LOCK     = 3'd5
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [1:0]        pending_ff, pending_in;
   logic              dir_neg_ff, dir_neg_in;
   logic signed [8:0] bias_ff, bias_in;
   logic [8:0]        hold_ff, hold_in;
   logic              ring_ff, ring_in;
   logic              valid_ff, valid_in;

   logic              take;
   logic              has_target;
   logic [7:0]        mag;
   logic signed [8:0] full_off;
   logic signed [8:0] shift_next;
   logic signed [8:0] return_next;
   logic [8:0]        hold_inc;

   function automatic logic signed [8:0] approach(input logic signed [8:0] v,
                                                  input logic signed [8:0] tgt,
                                                  input logic [5:0] step);
      logic signed [9:0] s;
      logic signed [9:0] t;
      s = {v[8], v};
      t = {tgt[8], tgt};
      if (s < t) begin
         s = s + $signed({4'b0000, step});
         if (s > t) begin
            s = t;
         end
      end else if (s > t) begin
         s = s - $signed({4'b0000, step});
         if (s < t) begin
            s = t;
         end
      end
      return s[8:0];
   endfunction

   assign item_ready = !valid_ff || out_ready;
   assign take       = item_valid && item_ready;
   assign has_target = (pending_ff == los_pkg::TARGET_LEFT) ||
                       (pending_ff == los_pkg::TARGET_RIGHT);

   always_comb begin
      if (dir_neg_ff) begin
         mag = ring_ff ? {1'b0, cfg.ring_right_max} : cfg.right_max;
      end else begin
         mag = ring_ff ? {1'b0, cfg.ring_left_max} : cfg.left_max;
      end
      full_off = dir_neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign shift_next  = approach(bias_ff, full_off, cfg.shift_step);
   assign return_next = approach(bias_ff, 9'sd0, cfg.return_step);
   assign hold_inc    = hold_ff + 9'd1;

   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      dir_neg_in = dir_neg_ff;
      bias_in    = bias_ff;
      hold_in    = hold_ff;
      ring_in    = ring_ff;
      valid_in   = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         case (item.req_type)
            los_pkg::REQ_TICK: begin
               case (mode_ff)
                  MODE_DISABLED: begin
                     bias_in    = 9'sd0;
                     dir_neg_in = 1'b0;
                     hold_in    = 9'd0;
                     ring_in    = 1'b0;
                  end
                  MODE_IDLE: begin
                     bias_in    = 9'sd0;
                     dir_neg_in = 1'b0;
                     hold_in    = 9'd0;
                     ring_in    = 1'b0;
                     if (has_target) begin
                        ring_in    = item.on_ring;
                        dir_neg_in = (pending_ff != los_pkg::TARGET_LEFT);
                        mode_in    = MODE_SHIFT;
                     end
                  end
                  MODE_SHIFT: begin
                     bias_in = shift_next;
                     if (shift_next == full_off) begin
                        hold_in = 9'd0;
                        mode_in = MODE_HOLD;
                     end
                  end
                  MODE_HOLD: begin
                     bias_in = full_off;
                     hold_in = hold_inc;
                     if (hold_inc >= cfg.hold_ticks) begin
                        hold_in = 9'd0;
                        mode_in = MODE_RETURN;
                     end
                  end
                  MODE_RETURN: begin
                     bias_in = return_next;
                     if (return_next == 9'sd0) begin
                        dir_neg_in = 1'b0;
                        hold_in    = 9'd0;
                        mode_in    = MODE_LOCK;
                     end
                  end
                  MODE_LOCK: begin
                     bias_in    = 9'sd0;
                     dir_neg_in = 1'b0;
                     if (!has_target) begin
                        pending_in = los_pkg::TARGET_NONE;
                        hold_in    = 9'd0;
                        ring_in    = 1'b0;
                        mode_in    = MODE_IDLE;
                     end
                  end
                  default: begin
                     mode_in    = MODE_IDLE;
                     pending_in = los_pkg::TARGET_NONE;
                     dir_neg_in = 1'b0;
                     bias_in    = 9'sd0;
                     hold_in    = 9'd0;
                     ring_in    = 1'b0;
                  end
               endcase
            end
            los_pkg::REQ_VISION: begin
               if (mode_ff != MODE_DISABLED) begin
                  pending_in = item.target_code;
               end
            end
            los_pkg::REQ_FORCE: begin
               if (mode_ff != MODE_DISABLED) begin
                  pending_in = los_pkg::TARGET_LEFT;
               end
            end
            los_pkg::REQ_ENABLE, los_pkg::REQ_DISABLE: begin
               mode_in    = (item.req_type == los_pkg::REQ_ENABLE) ?
                            MODE_IDLE : MODE_DISABLED;
               pending_in = los_pkg::TARGET_NONE;
               dir_neg_in = 1'b0;
               bias_in    = 9'sd0;
               hold_in    = 9'd0;
               ring_in    = 1'b0;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_DISABLED;
         pending_ff <= los_pkg::TARGET_NONE;
         dir_neg_ff <= 1'b0;
         bias_ff    <= 9'sd0;
         hold_ff    <= 9'd0;
         ring_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         dir_neg_ff <= dir_neg_in;
         bias_ff    <= bias_in;
         hold_ff    <= hold_in;
         ring_ff    <= ring_in;
         valid_ff   <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bias  = bias_ff;
   assign out_mode  = mode_ff;

endmodule

// ----- hw/rtl/lateral_offset_avoid_sequencer.sv -----
// Top level of the lateral offset avoid sequencer: input register, CSRs, core.
// Depends on los_pkg, los_csr and los_core.
//
//   group  dir  beat contents
//   req_   in   tuser: req_type; tdata: target_code, on_ring
//   rsp_   out  tdata: bias, mode; one beat per req beat
//   csr_   in   csr_we, csr_addr, csr_wdata; write only, no wait
//
// One beat per cycle sustained while rsp_tready stays high; a request beat passes
// through the input register, then the mode/bias state that forms the result.
// Reset is synchronous: mode disabled, bias zero, CSRs at their defaults.
// A stalled rsp_ side holds the result and lets one more request beat wait
// in the input register before req_tready drops.
module lateral_offset_avoid_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] target_code, [2] on_ring, [7:3] zero
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [8:0] bias, [11:9] mode, [15:12] zero
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);

   los_pkg::cfg_type  cfg;
   los_pkg::item_type item_ff, item_in;
   logic              item_valid_ff, item_valid_in;
   logic              core_ready;
   logic signed [8:0] bias;
   logic [2:0]        mode;
   logic              req_take;

   assign req_tready = !item_valid_ff || core_ready;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (core_ready) begin
         item_valid_in = 1'b0;
      end
      if (req_take) begin
         item_valid_in       = 1'b1;
         item_in.req_type    = req_tuser;
         item_in.target_code = req_tdata[1:0];
         item_in.on_ring     = req_tdata[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   los_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   los_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .item_ready (core_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bias   (bias),
      .out_mode   (mode)
   );

   assign rsp_tdata = {4'b0000, mode, bias};

endmodule
